// File: src/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg: shared definitions for the process time table
// Field widths, request codes and status codes of the table block.
// ----------------------------------------------------------------------------
package ptt_pkg;

  // field widths
  localparam int ID_W    = 22;
  localparam int TIME_W  = 32;
  localparam int REQ_W   = 3;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 7;

  // one stored entry: {time, id}
  localparam int ENTRY_W = ID_W + TIME_W;

  // a list never emits more words than this
  localparam int LIST_LIMIT = 64;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LIST   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUP      = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  // one result word, without the entry count
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [ID_W-1:0]   entry_id;
    logic [TIME_W-1:0] entry_time;
    logic              last_item;
  } res_t;

endpackage

// File: src/ptt_ram.sv
// ----------------------------------------------------------------------------
// ptt_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/process_time_table_top.sv
// ----------------------------------------------------------------------------
// process_time_table_top: ordered table of process id / cpu time entries
// Keeps up to MAX_ENTRIES entries in insertion order in one RAM and serves
// add, update, delete, lookup, list and clear requests.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser req_type, tdata id, time
//  out_    | out | out_tvalid/out_tready| tuser status, found; tdata entry
//          |     |                      | id, time, total; tlast last_item
//
// One request at a time. Add, update, lookup and delete walk the RAM one entry
// per cycle until the id is found or the entries run out. Delete then moves
// each entry behind the hit up one place to close the gap. List runs a read /
// load / hand-off sequence per entry on the single RAM read port.
// Reset clears the entry count, not the RAM contents; the RAM needs no clearing pass.
// A stalled output holds the sequencer; a new request is taken as soon as
// the sequencer is idle, even while the last result word waits.
module process_time_table_top #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  input  logic [55:0] in_tdata,   // [21:0] proc_id, [53:22] time_value, [55:54] zero
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // [1:0] status, [2] found
  output logic [63:0] out_tdata,  // [21:0] entry_id, [53:22] entry_time,
                                  // [60:54] entry_total, [63:61] zero
  output logic        out_tlast
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LIST_RD,
    S_LIST_WAIT,
    S_RESP
  } state_t;

  state_t                      state_r, state_nxt;
  logic [ptt_pkg::REQ_W-1:0]   req_r, req_nxt;
  logic [ptt_pkg::ID_W-1:0]    id_r, id_nxt;
  logic [ptt_pkg::TIME_W-1:0]  tm_r, tm_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic [CW-1:0]               chk_idx_r, chk_idx_nxt;
  ptt_pkg::res_t               res_r, res_nxt;
  ptt_pkg::res_t               out_res_r, out_res_nxt;
  logic [ptt_pkg::TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // RAM port signals
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic [ptt_pkg::ENTRY_W-1:0]  rd_data;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [ptt_pkg::ENTRY_W-1:0]  wr_data;

  logic          out_free;
  logic          hit;
  logic [CW-1:0] list_n;
  logic [CW-1:0] shift_dst;

  ptt_ram #(
    .WIDTH (ptt_pkg::ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // handshake outputs
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_res_r.found, out_res_r.status};
  assign out_tdata  = {3'b000, out_total_r, out_res_r.entry_time, out_res_r.entry_id};
  assign out_tlast  = out_res_r.last_item;

  // helpers
  assign out_free  = !out_valid_r || out_tready;
  assign hit       = chk_vld_r && (rd_data[ptt_pkg::ID_W-1:0] == id_r);
  assign shift_dst = chk_idx_r - CW'(1);

  always_comb begin
    if (32'(count_r) > ptt_pkg::LIST_LIMIT) begin
      list_n = CW'(ptt_pkg::LIST_LIMIT);
    end else begin
      list_n = count_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    id_nxt        = id_r;
    tm_nxt        = tm_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_total_nxt = out_total_r;
    out_valid_nxt = out_valid_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_data       = '0;

    // output word taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt     = in_tuser;
          id_nxt      = in_tdata[21:0];
          tm_nxt      = in_tdata[53:22];
          idx_nxt     = '0;
          chk_vld_nxt = 1'b0;
          res_nxt     = '{status: ptt_pkg::ST_OK, found: 1'b0, entry_id: '0,
                          entry_time: '0, last_item: 1'b1};
          case (in_tuser)
            ptt_pkg::REQ_ADD,
            ptt_pkg::REQ_UPDATE,
            ptt_pkg::REQ_DELETE,
            ptt_pkg::REQ_LOOKUP: state_nxt = S_SCAN;
            ptt_pkg::REQ_LIST: begin
              if (count_r == '0) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_LIST_RD;
              end
            end
            ptt_pkg::REQ_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_RESP;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end

      // walk the entries, one read issued per cycle
      S_SCAN: begin
        chk_vld_nxt = 1'b0;
        if (idx_r < count_r) begin
          rd_en       = 1'b1;
          idx_nxt     = idx_r + CW'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = idx_r;
        end
        if (hit) begin
          chk_vld_nxt = 1'b0;
          state_nxt   = S_RESP;
          case (req_r)
            ptt_pkg::REQ_ADD: res_nxt.status = ptt_pkg::ST_DUP;
            ptt_pkg::REQ_UPDATE: begin
              wr_en   = 1'b1;
              wr_addr = chk_idx_r[AW-1:0];
              wr_data = {tm_r, id_r};
            end
            ptt_pkg::REQ_DELETE: begin
              idx_nxt   = chk_idx_r + CW'(1);
              state_nxt = S_SHIFT;
            end
            ptt_pkg::REQ_LOOKUP: begin
              res_nxt.found      = 1'b1;
              res_nxt.entry_id   = rd_data[ptt_pkg::ID_W-1:0];
              res_nxt.entry_time = rd_data[ptt_pkg::ENTRY_W-1:ptt_pkg::ID_W];
            end
            default: ;
          endcase
        end else if (!chk_vld_r && (idx_r == count_r)) begin
          // id absent
          state_nxt = S_RESP;
          if (req_r == ptt_pkg::REQ_ADD) begin
            if (count_r < CW'(MAX_ENTRIES)) begin
              wr_en     = 1'b1;
              wr_addr   = count_r[AW-1:0];
              wr_data   = {{ptt_pkg::TIME_W{1'b0}}, id_r};
              count_nxt = count_r + CW'(1);
            end else begin
              res_nxt.status = ptt_pkg::ST_FULL;
            end
          end else begin
            res_nxt.status = ptt_pkg::ST_NOTFOUND;
          end
        end
      end

      // move each later entry up one place
      S_SHIFT: begin
        chk_vld_nxt = 1'b0;
        if (idx_r < count_r) begin
          rd_en       = 1'b1;
          idx_nxt     = idx_r + CW'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = idx_r;
        end
        if (chk_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = shift_dst[AW-1:0];
          wr_data = rd_data;
        end
        if (!chk_vld_r && (idx_r == count_r)) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end
      end

      S_LIST_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_LIST_WAIT;
      end

      S_LIST_WAIT: begin
        res_nxt.entry_id   = rd_data[ptt_pkg::ID_W-1:0];
        res_nxt.entry_time = rd_data[ptt_pkg::ENTRY_W-1:ptt_pkg::ID_W];
        res_nxt.last_item  = ((idx_r + CW'(1)) == list_n);
        state_nxt          = S_RESP;
      end

      // hand the word to the output register
      S_RESP: begin
        if (out_free) begin
          out_res_nxt   = res_r;
          out_total_nxt = ptt_pkg::TOTAL_W'(count_r);
          out_valid_nxt = 1'b1;
          if (res_r.last_item) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_LIST_RD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r       <= req_nxt;
    id_r        <= id_nxt;
    tm_r        <= tm_nxt;
    idx_r       <= idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
    out_total_r <= out_total_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request taken while busy");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_SCAN || state_r == S_SHIFT))
    else $error("RAM write outside scan or shift");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == ptt_pkg::REQ_CLEAR) |=> (count_r == '0))
    else $error("clear left entries");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (count_r != '0))
    else $error("delete on empty table");
`endif

endmodule
